// ----- rtl/gie_pkg.sv -----
`timescale 1ns / 1ps

package gie_pkg;

   localparam int ID_BITS_DEFAULT = 16;
   localparam int EMIT_BITS = 17;
   localparam logic [EMIT_BITS-1:0] EMIT_MAX = {EMIT_BITS{1'b1}};

   typedef enum logic [1:0] {
      ACT_EMIT  = 2'd0,
      ACT_ALIAS = 2'd1,
      ACT_INV   = 2'd2
   } action_type;

   // truth-table codes with special handling
   localparam logic [3:0] TT_ZERO = 4'h0;
   localparam logic [3:0] TT_ONE  = 4'hF;
   localparam logic [3:0] TT_XOR  = 4'h6;
   localparam logic [3:0] TT_AND  = 4'h1;
   localparam logic [3:0] TT_XNOR = 4'h9;
   localparam logic [3:0] TT_ANDN = 4'h4;

   // first input inverted: swap 3<->2 and 1<->0
   function automatic logic [3:0] fold_first(input logic [3:0] t);
      return {t[2], t[3], t[0], t[1]};
   endfunction

   // second input inverted: swap 3<->1 and 2<->0
   function automatic logic [3:0] fold_second(input logic [3:0] t);
      return {t[1], t[0], t[3], t[2]};
   endfunction

   // output gate with inverted input: two-bit table swapped, top bits cleared
   function automatic logic [3:0] fold_output(input logic [3:0] t);
      return {2'b00, t[0], t[1]};
   endfunction

endpackage

// ----- rtl/gate_identity_eliminator.sv -----
`timescale 1ns / 1ps

// Gate identity eliminator: takes one gate of a topologically ordered netlist per transfer
// and returns one result per gate (emitted, aliased or recorded as inverter). Sustained
// rate is one gate per clock while rsp_stall is low; each gate passes the alias memory
// read on the taking edge, the inverter memory read and the classify into the output
// register. Both memories have 2**ID_BITS entries; after reset a clearing pass over all
// 2**ID_BITS entries runs, one entry per cycle, with req_stall held high. Writes still in
// flight are forwarded into the read stages, so dependent gates may follow one another
// directly.
module gate_identity_eliminator #(
   parameter int ID_BITS = gie_pkg::ID_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ID_BITS-1:0]             req_gate_id,
   input  logic [ID_BITS-1:0]             req_src_a,
   input  logic [ID_BITS-1:0]             req_src_b,
   input  logic [3:0]                     req_truth_table,
   input  logic                           req_is_output,
   input  logic [7:0]                     req_party,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_action,
   output logic [ID_BITS-1:0]             rsp_out_id,
   output logic [ID_BITS-1:0]             rsp_out_a,
   output logic [ID_BITS-1:0]             rsp_out_b,
   output logic [3:0]                     rsp_out_table,
   output logic                           rsp_out_is_output,
   output logic [7:0]                     rsp_out_party,
   output logic [ID_BITS-1:0]             rsp_alias_target,
   output logic [ID_BITS-1:0]             rsp_max_gate_id,
   output logic [gie_pkg::EMIT_BITS-1:0]  rsp_emitted_count
);

   localparam int DEPTH = 2 ** ID_BITS;

   // memories: valid bit on top of the id
   logic [ID_BITS:0] alias_mem [DEPTH];
   logic [ID_BITS:0] inv_mem   [DEPTH];

   // clearing pass
   logic               clr_ff, clr_in;
   logic [ID_BITS-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: alias read data returned
   logic               s1_valid_ff, s1_valid_in;
   logic [ID_BITS-1:0] s1_id_ff, s1_src_a_ff, s1_src_b_ff;
   logic [3:0]         s1_tab_ff;
   logic               s1_out_ff;
   logic [7:0]         s1_party_ff;
   logic [ID_BITS:0]   al_rd_a_ff, al_rd_b_ff;

   // stage 2: inverter read data returned, classify
   logic               s2_valid_ff, s2_valid_in;
   logic [ID_BITS-1:0] s2_id_ff, s2_a_ff, s2_b_ff;
   logic [3:0]         s2_tab_ff;
   logic               s2_out_ff;
   logic [7:0]         s2_party_ff;
   logic [ID_BITS:0]   iv_rd_a_ff, iv_rd_b_ff;

   // most recent write to each memory
   logic               la_valid_ff, li_valid_ff;
   logic [ID_BITS-1:0] la_addr_ff, la_data_ff, li_addr_ff, li_data_ff;

   // scalar state
   logic [ID_BITS-1:0]            zero_ff, zero_in, one_ff, one_in;
   logic [ID_BITS-1:0]            largest_ff, largest_in;
   logic [gie_pkg::EMIT_BITS-1:0] emit_ff, emit_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   gie_pkg::action_type           rsp_action_ff;
   logic [ID_BITS-1:0]            rsp_id_ff, rsp_a_ff, rsp_b_ff, rsp_tgt_ff;
   logic [3:0]                    rsp_tab_ff;
   logic                          rsp_out_ff;
   logic [7:0]                    rsp_party_ff;

   logic req_xfer, adv1, adv2, s2_free, s1_free, out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign adv2     = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || adv2;
   assign adv1     = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || adv1;
   assign req_stall = clr_ff || !s1_free;
   assign req_xfer  = req_valid && !req_stall;

   // ---------------- stage 2 classify ----------------
   gie_pkg::action_type act;
   logic [ID_BITS-1:0]  tgt, fa, fb;
   logic [3:0]          ftab;
   logic [ID_BITS:0]    iv_a, iv_b;
   logic hz, ho, a_eq_b, a_z, b_z, a_o, b_o, cond4;

   always_comb begin
      iv_a = (li_valid_ff && li_addr_ff == s2_a_ff) ? {1'b1, li_data_ff} : iv_rd_a_ff;
      iv_b = (li_valid_ff && li_addr_ff == s2_b_ff) ? {1'b1, li_data_ff} : iv_rd_b_ff;
      fa   = s2_a_ff;
      fb   = s2_b_ff;
      ftab = s2_tab_ff;
      if (iv_a[ID_BITS]) begin
         fa   = iv_a[ID_BITS-1:0];
         ftab = s2_out_ff ? gie_pkg::fold_output(ftab) : gie_pkg::fold_first(ftab);
      end
      if (!s2_out_ff && iv_b[ID_BITS]) begin
         fb   = iv_b[ID_BITS-1:0];
         ftab = gie_pkg::fold_second(ftab);
      end

      hz     = zero_ff != '0;
      ho     = one_ff != '0;
      a_eq_b = fa == fb;
      a_z    = hz && fa == zero_ff;
      b_z    = hz && fb == zero_ff;
      a_o    = ho && fa == one_ff;
      b_o    = ho && fb == one_ff;
      cond4  = a_eq_b || (b_o && !(a_z || b_z) && fa != one_ff);

      act     = gie_pkg::ACT_EMIT;
      tgt     = '0;
      zero_in = zero_ff;
      one_in  = one_ff;
      if (s2_out_ff) begin
         act = gie_pkg::ACT_EMIT;
      end else begin
         unique case (ftab)
            gie_pkg::TT_ZERO: begin
               zero_in = s2_id_ff;
            end
            gie_pkg::TT_ONE: begin
               one_in = s2_id_ff;
            end
            gie_pkg::TT_XOR: begin
               priority if (a_eq_b) begin
                  if (!hz) begin
                     zero_in = s2_id_ff;
                  end else begin
                     act = gie_pkg::ACT_ALIAS; tgt = zero_ff;
                  end
               end else if (a_z) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fb;
               end else if (b_z) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fa;
               end else if (a_o) begin
                  act = gie_pkg::ACT_INV; tgt = fb;
               end else if (b_o) begin
                  act = gie_pkg::ACT_INV; tgt = fa;
               end else begin
                  act = gie_pkg::ACT_EMIT;
               end
            end
            gie_pkg::TT_AND: begin
               priority if (a_eq_b) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fa;
               end else if (a_o) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fb;
               end else if (b_o) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fa;
               end else if (a_z || b_z) begin
                  act = gie_pkg::ACT_ALIAS; tgt = zero_ff;
               end else begin
                  act = gie_pkg::ACT_EMIT;
               end
            end
            gie_pkg::TT_XNOR: begin
               priority if (a_eq_b) begin
                  if (!ho) begin
                     one_in = s2_id_ff;
                  end else begin
                     act = gie_pkg::ACT_ALIAS; tgt = one_ff;
                  end
               end else if (a_o) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fb;
               end else if (b_o) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fa;
               end else if (a_z) begin
                  act = gie_pkg::ACT_INV; tgt = fb;
               end else if (b_z) begin
                  act = gie_pkg::ACT_INV; tgt = fa;
               end else begin
                  act = gie_pkg::ACT_EMIT;
               end
            end
            gie_pkg::TT_ANDN: begin
               priority if (cond4) begin
                  if (!hz) begin
                     zero_in = s2_id_ff;
                  end else begin
                     act = gie_pkg::ACT_ALIAS; tgt = zero_ff;
                  end
               end else if (a_z) begin
                  act = gie_pkg::ACT_ALIAS; tgt = zero_ff;
               end else if (b_z) begin
                  act = gie_pkg::ACT_ALIAS; tgt = fa;
               end else if (a_o) begin
                  act = gie_pkg::ACT_INV; tgt = fb;
               end else begin
                  act = gie_pkg::ACT_EMIT;
               end
            end
            default: begin
               act = gie_pkg::ACT_EMIT;
            end
         endcase
      end
   end

   logic pend_alias, pend_inv;
   assign pend_alias = s2_valid_ff && act == gie_pkg::ACT_ALIAS;
   assign pend_inv   = s2_valid_ff && act == gie_pkg::ACT_INV;

   // ---------------- stage 1 alias resolve ----------------
   logic [ID_BITS-1:0] s1_a, s1_b;

   always_comb begin
      priority if (pend_alias && s2_id_ff == s1_src_a_ff) begin
         s1_a = tgt;
      end else if (la_valid_ff && la_addr_ff == s1_src_a_ff) begin
         s1_a = la_data_ff;
      end else if (al_rd_a_ff[ID_BITS]) begin
         s1_a = al_rd_a_ff[ID_BITS-1:0];
      end else begin
         s1_a = s1_src_a_ff;
      end
      priority if (pend_alias && s2_id_ff == s1_src_b_ff) begin
         s1_b = tgt;
      end else if (la_valid_ff && la_addr_ff == s1_src_b_ff) begin
         s1_b = la_data_ff;
      end else if (al_rd_b_ff[ID_BITS]) begin
         s1_b = al_rd_b_ff[ID_BITS-1:0];
      end else begin
         s1_b = s1_src_b_ff;
      end
   end

   // ---------------- memories ----------------
   logic               al_we, iv_we;
   logic [ID_BITS-1:0] mem_waddr;
   logic [ID_BITS:0]   al_wdata, iv_wdata;

   assign al_we     = clr_ff || (adv2 && act == gie_pkg::ACT_ALIAS);
   assign iv_we     = clr_ff || (adv2 && act == gie_pkg::ACT_INV);
   assign mem_waddr = clr_ff ? clr_addr_ff : s2_id_ff;
   assign al_wdata  = clr_ff ? '0 : {1'b1, tgt};
   assign iv_wdata  = clr_ff ? '0 : {1'b1, tgt};

   always_ff @(posedge clock) begin
      if (al_we) begin
         alias_mem[mem_waddr] <= al_wdata;
      end
      if (req_xfer) begin
         al_rd_a_ff <= alias_mem[req_src_a];
         al_rd_b_ff <= alias_mem[req_src_b];
      end
   end

   always_ff @(posedge clock) begin
      if (iv_we) begin
         inv_mem[mem_waddr] <= iv_wdata;
      end
      if (adv1) begin
         iv_rd_a_ff <= inv_mem[s1_a];
         iv_rd_b_ff <= inv_mem[s1_b];
      end
   end

   // ---------------- control next state ----------------
   always_comb begin
      clr_in      = clr_ff && clr_addr_ff != '1;
      clr_addr_in = clr_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
      s1_valid_in = req_xfer || (s1_valid_ff && !adv1);
      s2_valid_in = adv1 || (s2_valid_ff && !adv2);
      rsp_valid_in = adv2 || (rsp_valid_ff && rsp_stall);
      largest_in  = (largest_ff < s2_id_ff) ? s2_id_ff : largest_ff;
      emit_in     = emit_ff;
      if (act == gie_pkg::ACT_EMIT && emit_ff != gie_pkg::EMIT_MAX) begin
         emit_in = emit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         la_valid_ff  <= 1'b0;
         li_valid_ff  <= 1'b0;
         zero_ff      <= '0;
         one_ff       <= '0;
         largest_ff   <= '0;
         emit_ff      <= '0;
      end else begin
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv2) begin
            zero_ff    <= zero_in;
            one_ff     <= one_in;
            largest_ff <= largest_in;
            emit_ff    <= emit_in;
            if (pend_alias) begin
               la_valid_ff <= 1'b1;
            end
            if (pend_inv) begin
               li_valid_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_id_ff    <= req_gate_id;
         s1_src_a_ff <= req_src_a;
         s1_src_b_ff <= req_src_b;
         s1_tab_ff   <= req_truth_table;
         s1_out_ff   <= req_is_output;
         s1_party_ff <= req_party;
      end
      if (adv1) begin
         s2_id_ff    <= s1_id_ff;
         s2_a_ff     <= s1_a;
         s2_b_ff     <= s1_b;
         s2_tab_ff   <= s1_tab_ff;
         s2_out_ff   <= s1_out_ff;
         s2_party_ff <= s1_party_ff;
      end
      if (adv2) begin
         rsp_action_ff <= act;
         rsp_id_ff     <= s2_id_ff;
         rsp_a_ff      <= fa;
         rsp_b_ff      <= fb;
         rsp_tab_ff    <= ftab;
         rsp_out_ff    <= s2_out_ff;
         rsp_party_ff  <= s2_party_ff;
         rsp_tgt_ff    <= tgt;
      end
      if (adv2 && pend_alias) begin
         la_addr_ff <= s2_id_ff;
         la_data_ff <= tgt;
      end
      if (adv2 && pend_inv) begin
         li_addr_ff <= s2_id_ff;
         li_data_ff <= tgt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_out_a         = rsp_a_ff;
   assign rsp_out_b         = rsp_b_ff;
   assign rsp_out_table     = rsp_tab_ff;
   assign rsp_out_is_output = rsp_out_ff;
   assign rsp_out_party     = rsp_party_ff;
   assign rsp_alias_target  = rsp_tgt_ff;
   assign rsp_max_gate_id   = largest_ff;
   assign rsp_emitted_count = emit_ff;

   // ---------------- assertions ----------------
   a_emit_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (emit_ff == $past(emit_ff) || emit_ff == $past(emit_ff) + 1'b1))
      else $error("emit count moved by more than one");

   a_emit_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff == gie_pkg::ACT_EMIT |-> rsp_tgt_ff == '0)
      else $error("emitted gate carries an alias target");

   a_no_write_stalled: assert property (@(posedge clock) disable iff (reset)
      !clr_ff && (al_we || iv_we) |-> adv2)
      else $error("memory written without a stage 2 transfer");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted gate lost before stage 1");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline busy during clearing pass");

endmodule

// ----- verif/tb_gate_identity_eliminator.sv -----
`timescale 1ns / 1ps

module tb_gate_identity_eliminator;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] a;
      logic [15:0] b;
      logic [3:0]  tt;
      logic        is_out;
      logic [7:0]  party;
   } gate_type;

   typedef struct packed {
      gie_pkg::action_type action;
      logic [15:0] id;
      logic [15:0] a;
      logic [15:0] b;
      logic [3:0]  tt;
      logic        is_out;
      logic [7:0]  party;
      logic [15:0] target;
      logic [15:0] max_id;
      logic [16:0] emitted;
   } gate_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_gate_id = '0;
   logic [15:0] req_src_a = '0;
   logic [15:0] req_src_b = '0;
   logic [3:0]  req_truth_table = '0;
   logic        req_is_output = 1'b0;
   logic [7:0]  req_party = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic [15:0] rsp_out_id;
   logic [15:0] rsp_out_a;
   logic [15:0] rsp_out_b;
   logic [3:0]  rsp_out_table;
   logic        rsp_out_is_output;
   logic [7:0]  rsp_out_party;
   logic [15:0] rsp_alias_target;
   logic [15:0] rsp_max_gate_id;
   logic [gie_pkg::EMIT_BITS-1:0] rsp_emitted_count;

   // shadow of the eliminator state; bit 16 of a table entry is its valid flag
   bit [16:0] alias_mem [65536];
   bit [16:0] inv_mem [65536];
   bit [15:0] const0_id;
   bit [15:0] const1_id;
   bit [15:0] top_id;
   bit [16:0] emit_cnt;

   gate_verdict_type gate_verdicts [$];
   logic [15:0]   recent_ids [$];
   logic [15:0]   next_id;
   int unsigned   send_idle_pct = 0;
   int unsigned   stall_pct = 0;
   int unsigned   mismatch_count = 0;

   gate_identity_eliminator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_gate_id       (req_gate_id),
      .req_src_a         (req_src_a),
      .req_src_b         (req_src_b),
      .req_truth_table   (req_truth_table),
      .req_is_output     (req_is_output),
      .req_party         (req_party),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_a         (rsp_out_a),
      .rsp_out_b         (rsp_out_b),
      .rsp_out_table     (rsp_out_table),
      .rsp_out_is_output (rsp_out_is_output),
      .rsp_out_party     (rsp_out_party),
      .rsp_alias_target  (rsp_alias_target),
      .rsp_max_gate_id   (rsp_max_gate_id),
      .rsp_emitted_count (rsp_emitted_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // decide emit / alias / inverter for an already folded gate
   function automatic gie_pkg::action_type classify_gate(input logic [15:0] id,
                                                         input logic [15:0] a,
                                                         input logic [15:0] b,
                                                         input logic [3:0] tt,
                                                         output logic [15:0] tgt);
      logic hz;
      logic ho;
      hz = const0_id != 0;
      ho = const1_id != 0;
      tgt = '0;
      case (tt)
         gie_pkg::TT_ZERO: begin
            const0_id = id;
         end
         gie_pkg::TT_ONE: begin
            const1_id = id;
         end
         gie_pkg::TT_XOR: begin
            if (a == b) begin
               if (!hz) const0_id = id;
               else begin
                  tgt = const0_id;
                  return gie_pkg::ACT_ALIAS;
               end
            end else if (hz && a == const0_id) begin
               tgt = b;
               return gie_pkg::ACT_ALIAS;
            end else if (hz && b == const0_id) begin
               tgt = a;
               return gie_pkg::ACT_ALIAS;
            end else if (ho && a == const1_id) begin
               tgt = b;
               return gie_pkg::ACT_INV;
            end else if (ho && b == const1_id) begin
               tgt = a;
               return gie_pkg::ACT_INV;
            end
         end
         gie_pkg::TT_AND: begin
            if (a == b) begin
               tgt = a;
               return gie_pkg::ACT_ALIAS;
            end else if (ho && a == const1_id) begin
               tgt = b;
               return gie_pkg::ACT_ALIAS;
            end else if (ho && b == const1_id) begin
               tgt = a;
               return gie_pkg::ACT_ALIAS;
            end else if (hz && (a == const0_id || b == const0_id)) begin
               tgt = const0_id;
               return gie_pkg::ACT_ALIAS;
            end
         end
         gie_pkg::TT_XNOR: begin
            if (a == b) begin
               if (!ho) const1_id = id;
               else begin
                  tgt = const1_id;
                  return gie_pkg::ACT_ALIAS;
               end
            end else if (ho && a == const1_id) begin
               tgt = b;
               return gie_pkg::ACT_ALIAS;
            end else if (ho && b == const1_id) begin
               tgt = a;
               return gie_pkg::ACT_ALIAS;
            end else if (hz && a == const0_id) begin
               tgt = b;
               return gie_pkg::ACT_INV;
            end else if (hz && b == const0_id) begin
               tgt = a;
               return gie_pkg::ACT_INV;
            end
         end
         gie_pkg::TT_ANDN: begin
            if (a == b || (ho && b == const1_id && !(hz && (a == const0_id || b == const0_id))
                           && a != const1_id)) begin
               if (!hz) const0_id = id;
               else begin
                  tgt = const0_id;
                  return gie_pkg::ACT_ALIAS;
               end
            end else if (hz && a == const0_id) begin
               tgt = const0_id;
               return gie_pkg::ACT_ALIAS;
            end else if (hz && b == const0_id) begin
               tgt = a;
               return gie_pkg::ACT_ALIAS;
            end else if (ho && a == const1_id) begin
               tgt = b;
               return gie_pkg::ACT_INV;
            end
         end
         default: ;
      endcase
      return gie_pkg::ACT_EMIT;
   endfunction

   function automatic gate_verdict_type eliminate_gate(input gate_type g);
      gate_verdict_type v;
      logic [15:0]   a;
      logic [15:0]   b;
      logic [15:0]   tgt;
      logic [3:0]    tt;
      a = alias_mem[g.a][16] ? alias_mem[g.a][15:0] : g.a;
      b = alias_mem[g.b][16] ? alias_mem[g.b][15:0] : g.b;
      tt = g.tt;
      tgt = '0;
      if (top_id < g.id) top_id = g.id;
      if (!g.is_out) begin
         if (inv_mem[a][16]) begin
            tt = {tt[2], tt[3], tt[0], tt[1]};
            a = inv_mem[a][15:0];
         end
         if (inv_mem[b][16]) begin
            tt = {tt[1], tt[0], tt[3], tt[2]};
            b = inv_mem[b][15:0];
         end
         v.action = classify_gate(g.id, a, b, tt, tgt);
      end else begin
         // output gate: one input, two-bit table, always emitted
         if (inv_mem[a][16]) begin
            tt = {2'b00, tt[0], tt[1]};
            a = inv_mem[a][15:0];
         end
         v.action = gie_pkg::ACT_EMIT;
      end
      case (v.action)
         gie_pkg::ACT_EMIT:  if (emit_cnt != gie_pkg::EMIT_MAX) emit_cnt++;
         gie_pkg::ACT_ALIAS: alias_mem[g.id] = {1'b1, tgt};
         default:            inv_mem[g.id] = {1'b1, tgt};
      endcase
      v.id = g.id;
      v.a = a;
      v.b = b;
      v.tt = tt;
      v.is_out = g.is_out;
      v.party = g.party;
      v.target = tgt;
      v.max_id = top_id;
      v.emitted = emit_cnt;
      return v;
   endfunction

   function automatic string show_verdict(input gate_verdict_type v);
      return $sformatf("act=%0d id=%h a=%h b=%h tt=%h out=%b party=%h tgt=%h max=%h cnt=%h",
                       v.action, v.id, v.a, v.b, v.tt, v.is_out, v.party, v.target,
                       v.max_id, v.emitted);
   endfunction

   always @(posedge clock) begin
      gate_verdict_type got;
      gate_verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {gie_pkg::action_type'(rsp_action), rsp_out_id, rsp_out_a, rsp_out_b,
                rsp_out_table, rsp_out_is_output, rsp_out_party, rsp_alias_target,
                rsp_max_gate_id, rsp_emitted_count};
         if (gate_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result with no gate outstanding: %s", show_verdict(got));
         end else begin
            want = gate_verdicts.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("verdict mismatch\n  expected %s\n  actual   %s",
                           show_verdict(want), show_verdict(got));
            end
         end
      end
   end

   task automatic send_gate(input gate_type g);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gate_id <= g.id;
      req_src_a <= g.a;
      req_src_b <= g.b;
      req_truth_table <= g.tt;
      req_is_output <= g.is_out;
      req_party <= g.party;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gate_verdicts.push_back(eliminate_gate(g));
      recent_ids.push_back(g.id);
      if (recent_ids.size() > 12) void'(recent_ids.pop_front());
   endtask

   task automatic send_fields(input logic [15:0] id, input logic [15:0] a, input logic [15:0] b,
                              input logic [3:0] tt, input logic is_out);
      send_gate('{id, a, b, tt, is_out, 8'($urandom_range(0, 255))});
   endtask

   function automatic logic [15:0] pick_source();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12 && const0_id != 0) return const0_id;
      if (r >= 12 && r < 24 && const1_id != 0) return const1_id;
      if (r < 32 || recent_ids.size() == 0) return next_id - 16'($urandom_range(1, 64));
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
   endfunction

   function automatic logic [3:0] pick_table();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return gie_pkg::TT_ZERO;
      if (r == 1) return gie_pkg::TT_ONE;
      if (r < 5) return gie_pkg::TT_XOR;
      if (r < 8) return gie_pkg::TT_AND;
      if (r < 11) return gie_pkg::TT_XNOR;
      if (r < 14) return gie_pkg::TT_ANDN;
      return 4'($urandom_range(0, 15));
   endfunction

   task automatic run_netlist(input int unsigned count, input logic [15:0] base);
      gate_type    g;
      int unsigned r;
      next_id = base;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            // noise: any field value
            g = '{16'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                  1'($urandom), 8'($urandom)};
         end else begin
            g.a = pick_source();
            g.b = ($urandom_range(0, 4) == 0) ? g.a : pick_source();
            g.is_out = ($urandom_range(0, 99) < 8);
            g.tt = g.is_out ? 4'($urandom_range(0, 3)) : pick_table();
            g.party = 8'($urandom);
            if (r < 15 && recent_ids.size() != 0) begin
               // broken order: repeat an id already used
               g.id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
            end else begin
               g.id = next_id;
               next_id += 16'($urandom_range(1, 2));
            end
         end
         send_gate(g);
      end
   endtask

   task automatic test_directed_rules();
      send_fields(16'd1, 16'd3, 16'd4, gie_pkg::TT_ZERO, 1'b0);   // constant zero
      send_fields(16'd2, 16'd3, 16'd4, gie_pkg::TT_ONE, 1'b0);    // constant one
      send_fields(16'd5, 16'd3, 16'd3, gie_pkg::TT_XOR, 1'b0);    // x^x -> zero
      send_fields(16'd6, 16'd3, 16'd1, gie_pkg::TT_XOR, 1'b0);    // x^0 -> x
      send_fields(16'd7, 16'd3, 16'd2, gie_pkg::TT_XOR, 1'b0);    // x^1 -> inverter
      send_fields(16'd8, 16'd7, 16'd4, gie_pkg::TT_AND, 1'b0);    // inverted first input folded
      send_fields(16'd9, 16'd4, 16'd7, gie_pkg::TT_AND, 1'b0);    // inverted second input folded
      send_fields(16'd10, 16'd7, 16'd7, gie_pkg::TT_AND, 1'b0);
      send_fields(16'd11, 16'd3, 16'd3, gie_pkg::TT_XNOR, 1'b0);
      send_fields(16'd12, 16'd4, 16'd1, gie_pkg::TT_XNOR, 1'b0);
      send_fields(16'd13, 16'd4, 16'd2, gie_pkg::TT_ANDN, 1'b0);
      send_fields(16'd14, 16'd1, 16'd4, gie_pkg::TT_ANDN, 1'b0);
      send_fields(16'd15, 16'd4, 16'd1, gie_pkg::TT_ANDN, 1'b0);
      send_fields(16'd16, 16'd2, 16'd4, gie_pkg::TT_ANDN, 1'b0);
      send_fields(16'd17, 16'd5, 16'd4, gie_pkg::TT_AND, 1'b0);   // source through alias
      send_fields(16'd18, 16'd4, 16'd2, gie_pkg::TT_AND, 1'b0);
      send_fields(16'd19, 16'd4, 16'd4, gie_pkg::TT_AND, 1'b0);
      send_fields(16'd20, 16'd7, 16'd0, 4'b0001, 1'b1);  // output gate, inverted source
      send_fields(16'd21, 16'd4, 16'hFFFF, 4'b0010, 1'b1);
      send_gate('{16'hFFFF, 16'hFFFF, 16'h0000, 4'hE, 1'b0, 8'hFF});
      send_gate('{16'h0000, 16'h0000, 16'hFFFF, 4'h0, 1'b0, 8'h00});  // zero at id 0: none
      send_fields(16'd22, 16'd3, 16'd3, gie_pkg::TT_XOR, 1'b0);   // no zero known: becomes zero
      send_fields(16'd23, 16'd3, 16'd4, 4'hA, 1'b0);
   endtask

   task automatic test_netlist_no_idle();
      send_idle_pct = 0;
      stall_pct = 0;
      run_netlist(485, 16'h0020);
   endtask

   task automatic test_netlist_sender_idle();
      send_idle_pct = 47;
      stall_pct = 0;
      run_netlist(485, 16'h4000);
   endtask

   task automatic test_netlist_receiver_stall();
      send_idle_pct = 0;
      stall_pct = 47;
      run_netlist(485, 16'h8000);
   endtask

   task automatic test_netlist_both_idle();
      send_idle_pct = 35;
      stall_pct = 35;
      run_netlist(485, 16'hFC00);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_rules();
      test_netlist_no_idle();
      test_netlist_sender_idle();
      test_netlist_receiver_stall();
      test_netlist_both_idle();
      req_valid <= 1'b0;
      stall_pct = 0;
      while (gate_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // the clearing pass after reset covers all 65536 entries; the rest fits well inside this timeout
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/gie_pkg.sv
rtl/gate_identity_eliminator.sv
verif/tb_gate_identity_eliminator.sv
